FILE: src/vau_pkg.sv
package vau_pkg;

    localparam int CMD_W = 4;

    // Command code map.
    localparam logic [CMD_W-1:0] CMD_VV_LO = 4'd0;
    localparam logic [CMD_W-1:0] CMD_VV_HI = 4'd3;
    localparam logic [CMD_W-1:0] CMD_VS_LO = 4'd4;
    localparam logic [CMD_W-1:0] CMD_VS_HI = 4'd7;
    localparam logic [CMD_W-1:0] CMD_SV_LO = 4'd8;
    localparam logic [CMD_W-1:0] CMD_SV_HI = 4'd11;
    localparam logic [CMD_W-1:0] CMD_DOT   = 4'd12;
    localparam logic [CMD_W-1:0] CMD_LEN   = 4'd13;
    localparam logic [CMD_W-1:0] CMD_NORM  = 4'd14;

    // Element operation, taken from the two low bits of the command.
    typedef enum logic [1:0] {
        OP_ADD,
        OP_SUB,
        OP_MUL,
        OP_DIV
    } t_op;

    // Command class: where the operands come from and which result is used.
    typedef enum logic [2:0] {
        CLS_VV,
        CLS_VS,
        CLS_SV,
        CLS_DOT,
        CLS_LEN,
        CLS_NORM,
        CLS_NONE
    } t_cls;

    function automatic t_cls cmd_class(input logic [CMD_W-1:0] cmd);
        t_cls c;
        if (cmd inside {[CMD_VV_LO:CMD_VV_HI]}) begin
            c = CLS_VV;
        end else if (cmd inside {[CMD_VS_LO:CMD_VS_HI]}) begin
            c = CLS_VS;
        end else if (cmd inside {[CMD_SV_LO:CMD_SV_HI]}) begin
            c = CLS_SV;
        end else if (cmd == CMD_DOT) begin
            c = CLS_DOT;
        end else if (cmd == CMD_LEN) begin
            c = CLS_LEN;
        end else if (cmd == CMD_NORM) begin
            c = CLS_NORM;
        end else begin
            c = CLS_NONE;
        end
        return c;
    endfunction

    function automatic t_op cmd_op(input logic [CMD_W-1:0] cmd);
        return t_op'(cmd[1:0]);
    endfunction

endpackage

FILE: src/vau_lane.sv
module vau_lane
    import vau_pkg::*;
#(
    parameter int W = 32,
    parameter int F = 16
) (
    input  logic           i_clk,
    input  logic           i_adv,
    input  t_cls           i_cls,
    input  t_op            i_op,
    input  logic [W-1:0]   i_a,
    input  logic [W-1:0]   i_b,
    input  logic [W-1:0]   i_s,
    output logic [2*W-1:0] o_prod,
    output logic           o_prod_neg,
    output logic [W-1:0]   o_res,
    output logic           o_ovf,
    output logic           o_xn,
    output logic [W-1:0]   o_xm,
    output logic           o_yn,
    output logic [W-1:0]   o_ym
);

    // Saturate a sign and magnitude to W bits; the top bit of the result is the overflow.
    function automatic logic [W:0] sat(input logic neg, input logic [2*W-1:0] mag);
        logic [2*W-1:0] lim;
        logic [W-1:0]   v;
        logic           o;
        lim = {{W{1'b0}}, neg, {(W-1){~neg}}};
        o   = mag > lim;
        if (o) begin
            v = {neg, {(W-1){~neg}}};
        end else begin
            v = neg ? (~mag[W-1:0] + 1'b1) : mag[W-1:0];
        end
        return {o, v};
    endfunction

    logic [W-1:0] x, y;
    logic [W-1:0] xm, ym;

    always_comb begin
        x = i_a;
        y = i_b;
        case (i_cls)
            CLS_VS: begin
                y = i_s;
            end
            CLS_SV: begin
                x = i_s;
                y = i_a;
            end
            CLS_LEN, CLS_NORM: begin
                y = i_a;
            end
            default: begin
                y = i_b;
            end
        endcase
        xm = x[W-1] ? (~x + 1'b1) : x;
        ym = y[W-1] ? (~y + 1'b1) : y;
    end

    // Operand stage.
    logic         r_xn_a, r_yn_a;
    logic [W-1:0] r_xm_a, r_ym_a;
    t_op          r_op_a;

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_xn_a <= x[W-1];
            r_yn_a <= y[W-1];
            r_xm_a <= xm;
            r_ym_a <= ym;
            r_op_a <= i_op;
        end
    end

    // Product and signed add stage.
    logic         add_yn;
    logic         add_neg;
    logic [W:0]   add_mag;
    logic [W:0]   n_add;

    always_comb begin
        add_yn = r_yn_a ^ (r_op_a == OP_SUB);
        if (r_xn_a == add_yn) begin
            add_mag = {1'b0, r_xm_a} + {1'b0, r_ym_a};
            add_neg = r_xn_a;
        end else if (r_xm_a >= r_ym_a) begin
            add_mag = {1'b0, r_xm_a - r_ym_a};
            add_neg = r_xn_a;
        end else begin
            add_mag = {1'b0, r_ym_a - r_xm_a};
            add_neg = add_yn;
        end
        n_add = sat(add_neg, (2*W)'(add_mag));
    end

    logic [2*W-1:0] r_prod_b;
    logic           r_pneg_b;
    logic [W:0]     r_add_b;
    logic           r_xn_b, r_yn_b;
    logic [W-1:0]   r_xm_b, r_ym_b;
    t_op            r_op_b;

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_prod_b <= {{W{1'b0}}, r_xm_a} * {{W{1'b0}}, r_ym_a};
            r_pneg_b <= r_xn_a ^ r_yn_a;
            r_add_b  <= n_add;
            r_xn_b   <= r_xn_a;
            r_yn_b   <= r_yn_a;
            r_xm_b   <= r_xm_a;
            r_ym_b   <= r_ym_a;
            r_op_b   <= r_op_a;
        end
    end

    // Product scaling and choice of the early result.
    logic [W:0] n_mul;
    assign n_mul = sat(r_pneg_b, r_prod_b >> F);

    logic [W:0]   r_res_c;
    logic         r_xn_c, r_yn_c;
    logic [W-1:0] r_xm_c, r_ym_c;

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_res_c <= (r_op_b == OP_MUL) ? n_mul : r_add_b;
            r_xn_c  <= r_xn_b;
            r_yn_c  <= r_yn_b;
            r_xm_c  <= r_xm_b;
            r_ym_c  <= r_ym_b;
        end
    end

    assign o_prod     = r_prod_b;
    assign o_prod_neg = r_pneg_b;
    assign o_res      = r_res_c[W-1:0];
    assign o_ovf      = r_res_c[W];
    assign o_xn       = r_xn_c;
    assign o_xm       = r_xm_c;
    assign o_yn       = r_yn_c;
    assign o_ym       = r_ym_c;

endmodule

FILE: src/vau_sqrt.sv
module vau_sqrt #(
    parameter int RW    = 66,
    parameter int TAG_W = 8
) (
    input  logic              i_clk,
    input  logic              i_adv,
    input  logic [RW-1:0]     i_rad,
    input  logic [TAG_W-1:0]  i_tag,
    output logic [RW/2-1:0]   o_root,
    output logic [TAG_W-1:0]  o_tag
);

    localparam int QW   = RW / 2;
    localparam int REMW = QW + 2;

    logic [RW-1:0]    r_rad  [QW];
    logic [REMW-1:0]  r_rem  [QW];
    logic [QW-1:0]    r_root [QW];
    logic [TAG_W-1:0] r_tag  [QW];

    logic [RW-1:0]    n_rad  [QW];
    logic [REMW-1:0]  n_rem  [QW];
    logic [QW-1:0]    n_root [QW];
    logic [TAG_W-1:0] n_tag  [QW];

    // One root bit per stage, two radicand bits consumed per stage.
    always_comb begin
        logic [RW-1:0]    p_rad;
        logic [REMW-1:0]  p_rem;
        logic [QW-1:0]    p_root;
        logic [REMW+1:0]  trial;
        logic [REMW+1:0]  tst;
        logic [REMW+1:0]  diff;
        for (int s = 0; s < QW; s++) begin
            if (s == 0) begin
                p_rad  = i_rad;
                p_rem  = '0;
                p_root = '0;
                n_tag[s] = i_tag;
            end else begin
                p_rad  = r_rad[s-1];
                p_rem  = r_rem[s-1];
                p_root = r_root[s-1];
                n_tag[s] = r_tag[s-1];
            end
            trial = {p_rem, p_rad[RW-1 -: 2]};
            tst   = {2'b00, p_root, 2'b01};
            diff  = trial - tst;
            if (trial >= tst) begin
                n_rem[s]  = diff[REMW-1:0];
                n_root[s] = {p_root[QW-2:0], 1'b1};
            end else begin
                n_rem[s]  = trial[REMW-1:0];
                n_root[s] = {p_root[QW-2:0], 1'b0};
            end
            n_rad[s] = p_rad << 2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            for (int s = 0; s < QW; s++) begin
                r_rad[s]  <= n_rad[s];
                r_rem[s]  <= n_rem[s];
                r_root[s] <= n_root[s];
                r_tag[s]  <= n_tag[s];
            end
        end
    end

    assign o_root = r_root[QW-1];
    assign o_tag  = r_tag[QW-1];

endmodule

FILE: src/vau_div.sv
module vau_div #(
    parameter int NW    = 48,
    parameter int DW    = 33,
    parameter int TAG_W = 8
) (
    input  logic             i_clk,
    input  logic             i_adv,
    input  logic [NW-1:0]    i_num,
    input  logic [DW-1:0]    i_den,
    input  logic [TAG_W-1:0] i_tag,
    output logic [NW-1:0]    o_quo,
    output logic [TAG_W-1:0] o_tag
);

    logic [NW-1:0]    r_num [NW];
    logic [DW-1:0]    r_rem [NW];
    logic [DW-1:0]    r_den [NW];
    logic [NW-1:0]    r_quo [NW];
    logic [TAG_W-1:0] r_tag [NW];

    logic [NW-1:0]    n_num [NW];
    logic [DW-1:0]    n_rem [NW];
    logic [DW-1:0]    n_den [NW];
    logic [NW-1:0]    n_quo [NW];
    logic [TAG_W-1:0] n_tag [NW];

    // Restoring division, one quotient bit per stage, most significant first.
    always_comb begin
        logic [NW-1:0] p_num;
        logic [DW-1:0] p_rem;
        logic [DW-1:0] p_den;
        logic [NW-1:0] p_quo;
        logic [DW:0]   trial;
        logic [DW:0]   diff;
        for (int s = 0; s < NW; s++) begin
            if (s == 0) begin
                p_num = i_num;
                p_rem = '0;
                p_den = i_den;
                p_quo = '0;
                n_tag[s] = i_tag;
            end else begin
                p_num = r_num[s-1];
                p_rem = r_rem[s-1];
                p_den = r_den[s-1];
                p_quo = r_quo[s-1];
                n_tag[s] = r_tag[s-1];
            end
            trial = {p_rem, p_num[NW-1]};
            diff  = trial - {1'b0, p_den};
            if (trial >= {1'b0, p_den}) begin
                n_rem[s] = diff[DW-1:0];
                n_quo[s] = {p_quo[NW-2:0], 1'b1};
            end else begin
                n_rem[s] = trial[DW-1:0];
                n_quo[s] = {p_quo[NW-2:0], 1'b0};
            end
            n_num[s] = p_num << 1;
            n_den[s] = p_den;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            for (int s = 0; s < NW; s++) begin
                r_num[s] <= n_num[s];
                r_rem[s] <= n_rem[s];
                r_den[s] <= n_den[s];
                r_quo[s] <= n_quo[s];
                r_tag[s] <= n_tag[s];
            end
        end
    end

    assign o_quo = r_quo[NW-1];
    assign o_tag = r_tag[NW-1];

endmodule

FILE: src/vec4_arithmetic_unit_top.sv
// Four-component vector arithmetic unit, signed fixed point (Q16.16 by default).
//
// Input channel: i_valid/o_ready carry one word holding a command, vectors a and b
// and a scalar. Output channel: o_valid/i_ready carry one result word: a vector,
// a scalar (dot product or length), an overflow flag and a divide-by-zero flag.
// A word moves on a rising edge where valid and ready are both high.
//
// The block is one pipeline of 2*DATA_WIDTH + FRAC_BITS + 5 stages: three
// stages of operand select, multiply and sum, one square-root stage per root bit,
// one divider stage per quotient bit, and the output register. Every command runs
// the full pipeline, so results leave in the order their words came in. Throughput
// is one word per cycle unless the receiver stalls the output.
//
// Four lanes each handle one vector component; a merge stage sums their
// products for the dot product and the sum of squares feeding the square root.
//
// When the receiver holds i_ready low while a result waits, the whole pipeline
// freezes and o_ready drops; nothing is lost. Reset clears every valid bit.
module vec4_arithmetic_unit_top
    import vau_pkg::*;
#(
    parameter int DATA_WIDTH = 32,
    parameter int FRAC_BITS  = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  logic [CMD_W-1:0]      i_command,
    input  logic [DATA_WIDTH-1:0] i_a_x,
    input  logic [DATA_WIDTH-1:0] i_a_y,
    input  logic [DATA_WIDTH-1:0] i_a_z,
    input  logic [DATA_WIDTH-1:0] i_a_w,
    input  logic [DATA_WIDTH-1:0] i_b_x,
    input  logic [DATA_WIDTH-1:0] i_b_y,
    input  logic [DATA_WIDTH-1:0] i_b_z,
    input  logic [DATA_WIDTH-1:0] i_b_w,
    input  logic [DATA_WIDTH-1:0] i_scalar_operand,
    output logic                  o_valid,
    input  logic                  i_ready,
    output logic [DATA_WIDTH-1:0] o_r_x,
    output logic [DATA_WIDTH-1:0] o_r_y,
    output logic [DATA_WIDTH-1:0] o_r_z,
    output logic [DATA_WIDTH-1:0] o_r_w,
    output logic [DATA_WIDTH-1:0] o_scalar_result,
    output logic                  o_overflow_flag,
    output logic                  o_divide_by_zero
);

    localparam int W   = DATA_WIDTH;
    localparam int F   = FRAC_BITS;
    localparam int SW  = 2 * W + 2;          // signed sum of four products
    localparam int QW  = SW / 2;             // square-root width
    localparam int NW  = W + F;              // dividend and quotient width
    localparam int MW  = (SW > NW) ? SW : NW;
    localparam int LAT = 3 + QW + NW + 1;

    // Per-lane data carried through the square-root stages.
    typedef struct packed {
        logic [W-1:0] res;
        logic         ovf;
        logic         xn;
        logic [W-1:0] xm;
        logic         yn;
        logic [W-1:0] ym;
    } t_lane_c;

    typedef struct packed {
        t_cls          cls;
        t_op           op;
        logic [W-1:0]  dot;
        logic          dot_ovf;
        t_lane_c [3:0] ln;
    } t_sq_tag;

    // Per-lane data carried through the divider.
    typedef struct packed {
        logic [W-1:0] res;
        logic         ovf;
        logic         dz;
        logic         qneg;
        logic         xzero;
        logic         xn;
    } t_dv_tag;

    // Command-wide data delayed alongside the dividers.
    typedef struct packed {
        t_cls         cls;
        t_op          op;
        logic [W-1:0] dot;
        logic         dot_ovf;
        logic [W-1:0] len;
        logic         len_ovf;
    } t_shr;

    function automatic logic [W:0] sat(input logic neg, input logic [MW-1:0] mag);
        logic [MW-1:0] lim;
        logic [W-1:0]  v;
        logic          o;
        lim = MW'({neg, {(W-1){~neg}}});
        o   = mag > lim;
        if (o) begin
            v = {neg, {(W-1){~neg}}};
        end else begin
            v = neg ? (~mag[W-1:0] + 1'b1) : mag[W-1:0];
        end
        return {o, v};
    endfunction

    // Handshake and valid tracking. The pipeline moves as one.
    logic           adv;
    logic [LAT-1:0] r_vld;

    assign adv     = !r_vld[LAT-1] || i_ready;
    assign o_ready = adv;
    assign o_valid = r_vld[LAT-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (adv) begin
            r_vld <= {r_vld[LAT-2:0], i_valid};
        end
    end

    // Command decode, carried through the lane stages.
    t_cls in_cls;
    t_op  in_op;
    assign in_cls = cmd_class(i_command);
    assign in_op  = cmd_op(i_command);

    t_cls r_cls_a, r_cls_b, r_cls_c;
    t_op  r_op_a, r_op_b, r_op_c;

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_cls_a <= in_cls;
            r_op_a  <= in_op;
            r_cls_b <= r_cls_a;
            r_op_b  <= r_op_a;
            r_cls_c <= r_cls_b;
            r_op_c  <= r_op_b;
        end
    end

    // Lanes.
    logic [W-1:0]   in_a [4];
    logic [W-1:0]   in_b [4];
    logic [2*W-1:0] ln_prod [4];
    logic           ln_pneg [4];
    t_lane_c        ln_c [4];

    assign in_a[0] = i_a_x;
    assign in_a[1] = i_a_y;
    assign in_a[2] = i_a_z;
    assign in_a[3] = i_a_w;
    assign in_b[0] = i_b_x;
    assign in_b[1] = i_b_y;
    assign in_b[2] = i_b_z;
    assign in_b[3] = i_b_w;

    for (genvar i = 0; i < 4; i++) begin : g_lane
        vau_lane #(
            .W (W),
            .F (F)
        ) u_lane (
            .i_clk      (i_clk),
            .i_adv      (adv),
            .i_cls      (in_cls),
            .i_op       (in_op),
            .i_a        (in_a[i]),
            .i_b        (in_b[i]),
            .i_s        (i_scalar_operand),
            .o_prod     (ln_prod[i]),
            .o_prod_neg (ln_pneg[i]),
            .o_res      (ln_c[i].res),
            .o_ovf      (ln_c[i].ovf),
            .o_xn       (ln_c[i].xn),
            .o_xm       (ln_c[i].xm),
            .o_yn       (ln_c[i].yn),
            .o_ym       (ln_c[i].ym)
        );
    end

    // Merge: signed sum of the four lane products. For length and normalize the
    // lanes square a, so this is the sum of squares.
    logic [SW-1:0] n_sum;
    logic [SW-1:0] r_sum;

    always_comb begin
        logic [SW-1:0] term;
        n_sum = '0;
        for (int i = 0; i < 4; i++) begin
            term  = {2'b00, ln_prod[i]};
            n_sum = n_sum + (ln_pneg[i] ? (~term + 1'b1) : term);
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_sum <= n_sum;
        end
    end

    logic          sum_neg;
    logic [SW-1:0] sum_mag;
    logic [W:0]    dot_pk;
    t_sq_tag       sq_in;

    assign sum_neg = r_sum[SW-1];
    assign sum_mag = sum_neg ? (~r_sum + 1'b1) : r_sum;
    assign dot_pk  = sat(sum_neg, MW'(sum_mag >> F));

    always_comb begin
        sq_in.cls     = r_cls_c;
        sq_in.op      = r_op_c;
        sq_in.dot     = dot_pk[W-1:0];
        sq_in.dot_ovf = dot_pk[W];
        for (int i = 0; i < 4; i++) begin
            sq_in.ln[i] = ln_c[i];
        end
    end

    logic [QW-1:0]        sq_root;
    logic [$bits(t_sq_tag)-1:0] sq_tag_raw;
    t_sq_tag              sq_out;

    vau_sqrt #(
        .RW    (SW),
        .TAG_W ($bits(t_sq_tag))
    ) u_sqrt (
        .i_clk  (i_clk),
        .i_adv  (adv),
        .i_rad  (sum_mag),
        .i_tag  (sq_in),
        .o_root (sq_root),
        .o_tag  (sq_tag_raw)
    );

    assign sq_out = t_sq_tag'(sq_tag_raw);

    // Divider setup: element divides use the lane's own divisor, normalize uses
    // the unsaturated length of a.
    logic [NW-1:0] dv_num [4];
    logic [QW-1:0] dv_den [4];
    t_dv_tag       dv_in  [4];
    logic          is_norm;
    logic [W:0]    len_pk;
    t_shr          n_shr;

    assign is_norm = (sq_out.cls == CLS_NORM);
    assign len_pk  = sat(1'b0, MW'(sq_root));

    always_comb begin
        for (int i = 0; i < 4; i++) begin
            dv_num[i]      = {sq_out.ln[i].xm, {F{1'b0}}};
            dv_den[i]      = is_norm ? sq_root : {1'b0, sq_out.ln[i].ym};
            dv_in[i].res   = sq_out.ln[i].res;
            dv_in[i].ovf   = sq_out.ln[i].ovf;
            dv_in[i].dz    = (dv_den[i] == '0);
            dv_in[i].qneg  = is_norm ? sq_out.ln[i].xn : (sq_out.ln[i].xn ^ sq_out.ln[i].yn);
            dv_in[i].xzero = (sq_out.ln[i].xm == '0);
            dv_in[i].xn    = sq_out.ln[i].xn;
        end
        n_shr.cls     = sq_out.cls;
        n_shr.op      = sq_out.op;
        n_shr.dot     = sq_out.dot;
        n_shr.dot_ovf = sq_out.dot_ovf;
        n_shr.len     = len_pk[W-1:0];
        n_shr.len_ovf = len_pk[W];
    end

    logic [NW-1:0]              dv_quo     [4];
    logic [$bits(t_dv_tag)-1:0] dv_tag_raw [4];
    t_dv_tag                    dv_out     [4];

    for (genvar i = 0; i < 4; i++) begin : g_div
        vau_div #(
            .NW    (NW),
            .DW    (QW),
            .TAG_W ($bits(t_dv_tag))
        ) u_div (
            .i_clk (i_clk),
            .i_adv (adv),
            .i_num (dv_num[i]),
            .i_den (dv_den[i]),
            .i_tag (dv_in[i]),
            .o_quo (dv_quo[i]),
            .o_tag (dv_tag_raw[i])
        );
        assign dv_out[i] = t_dv_tag'(dv_tag_raw[i]);
    end

    t_shr r_shr [NW];

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_shr[0] <= n_shr;
            for (int s = 1; s < NW; s++) begin
                r_shr[s] <= r_shr[s-1];
            end
        end
    end

    // Final selection and saturation of each lane.
    t_shr         shr_o;
    logic         use_div;
    logic         use_elem;
    logic [W:0]   q_pk  [4];
    logic [W-1:0] n_res [4];
    logic         n_lovf [4];
    logic         n_ldz  [4];
    logic [W-1:0] n_scalar;
    logic         n_ovf;
    logic         n_dz;

    assign shr_o = r_shr[NW-1];

    always_comb begin
        use_elem = (shr_o.cls == CLS_VV) || (shr_o.cls == CLS_VS) || (shr_o.cls == CLS_SV);
        use_div  = (use_elem && (shr_o.op == OP_DIV)) || (shr_o.cls == CLS_NORM);
        n_ovf    = 1'b0;
        n_dz     = 1'b0;
        for (int i = 0; i < 4; i++) begin
            q_pk[i] = sat(dv_out[i].qneg, MW'(dv_quo[i]));
            if (use_div) begin
                if (dv_out[i].dz) begin
                    // Divide by zero saturates by the dividend's sign; zero over zero is zero.
                    n_res[i]  = dv_out[i].xzero ? '0 :
                                {dv_out[i].xn, {(W-1){~dv_out[i].xn}}};
                    n_lovf[i] = 1'b0;
                    n_ldz[i]  = 1'b1;
                end else begin
                    n_res[i]  = q_pk[i][W-1:0];
                    n_lovf[i] = q_pk[i][W];
                    n_ldz[i]  = 1'b0;
                end
            end else if (use_elem) begin
                n_res[i]  = dv_out[i].res;
                n_lovf[i] = dv_out[i].ovf;
                n_ldz[i]  = 1'b0;
            end else begin
                n_res[i]  = '0;
                n_lovf[i] = 1'b0;
                n_ldz[i]  = 1'b0;
            end
            n_ovf = n_ovf | n_lovf[i];
            n_dz  = n_dz | n_ldz[i];
        end
        case (shr_o.cls)
            CLS_DOT: begin
                n_scalar = shr_o.dot;
                n_ovf    = shr_o.dot_ovf;
            end
            CLS_LEN: begin
                n_scalar = shr_o.len;
                n_ovf    = shr_o.len_ovf;
            end
            default: begin
                n_scalar = '0;
            end
        endcase
    end

    logic [W-1:0] r_out_x, r_out_y, r_out_z, r_out_w, r_out_s;
    logic         r_out_ovf, r_out_dz;
    t_cls         r_cls_o;

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_out_x   <= n_res[0];
            r_out_y   <= n_res[1];
            r_out_z   <= n_res[2];
            r_out_w   <= n_res[3];
            r_out_s   <= n_scalar;
            r_out_ovf <= n_ovf;
            r_out_dz  <= n_dz;
            r_cls_o   <= shr_o.cls;
        end
    end

    assign o_r_x            = r_out_x;
    assign o_r_y            = r_out_y;
    assign o_r_z            = r_out_z;
    assign o_r_w            = r_out_w;
    assign o_scalar_result  = r_out_s;
    assign o_overflow_flag  = r_out_ovf;
    assign o_divide_by_zero = r_out_dz;

    // A scalar result and a vector result never appear in the same word.
    a_scalar_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_scalar_result != '0) |->
            (o_r_x == '0) && (o_r_y == '0) && (o_r_z == '0) && (o_r_w == '0))
        else $error("scalar and vector results both nonzero");

    // A length is never negative, even when it saturates.
    a_len_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (r_cls_o == CLS_LEN) |-> !o_scalar_result[W-1])
        else $error("negative length");

    // Only a divide or a normalize can flag division by zero.
    a_dz_cls: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_divide_by_zero |->
            (r_cls_o == CLS_VV) || (r_cls_o == CLS_VS) ||
            (r_cls_o == CLS_SV) || (r_cls_o == CLS_NORM))
        else $error("divide-by-zero flag on a command without division");

    // Reset empties the pipeline.
    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result word valid right after reset");

endmodule
